// File: design/ffba_pkg.sv
// Shared constants, codes and types of the first-fit bitmap allocator.
package ffba_pkg;

    localparam int HEAP_WORDS = 256;
    localparam int ROW_BITS   = 8;
    localparam int ROWS       = HEAP_WORDS / ROW_BITS;
    localparam int ROW_SH     = $clog2(ROW_BITS);
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int OFF_W      = $clog2(HEAP_WORDS);
    localparam int HINT_W     = OFF_W + 1;
    localparam int SIZE_W     = 9;
    localparam int CMD_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_COMMIT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW,
        ST_SEEK_RD,
        ST_SEEK,
        ST_DONE
    } state_t;

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [ROW_AW-1:0]   row_addr_t;

    typedef struct packed {
        logic      rd_en;
        row_addr_t rd_row;
        logic      wr_in_use;
        logic      wr_ever;
        row_addr_t wr_row;
        row_t      in_use_data;
        row_t      ever_data;
    } map_req_t;

    typedef struct packed {
        row_t in_use;
        row_t ever;
    } map_rsp_t;

endpackage

// File: design/first_fit_bitmap_allocator.sv
// Top level of the first-fit bitmap allocator: command sequencer around the bitmap memories.
//
// Request channel (req_valid / req_stall) carries cmd, block_size and start_offset;
// response channel (rsp_valid / rsp_stall) returns status and granted_offset, one
// response per request, in order. A transfer happens on a clock edge with valid high
// and stall low. One item is worked at a time; req_stall is low only while idle.
// The maps live in memories of 8-word rows with a registered read; every pass walks
// one row per cycle. The passes of each command:
//   allocate: a scan pass, then a mark pass over the rows of a found run (then a seek read
//             and a seek pass when the run began at the first-free hint and ends below
//             the heap end); zero-size or oversized requests go straight to the response
//   free:     one pass over the rows in the range (none when block_size is zero)
//   commit:   one pass over all 32 rows
// A finished response waits in an output register, so a stalled receiver blocks
// only the next response, not the acceptance of the next item.
// Reset clears the hint and marks every map row as free through per-row valid bits;
// the block is idle and accepts an item as soon as reset ends.
module first_fit_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [ffba_pkg::CMD_W-1:0]    cmd,
    input  logic [ffba_pkg::SIZE_W-1:0]   block_size,
    input  logic [ffba_pkg::OFF_W-1:0]    start_offset,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          status,
    output logic [ffba_pkg::OFF_W-1:0]    granted_offset
);

    localparam int CMP_W  = ffba_pkg::HINT_W + 1;
    localparam int FREE_W = ffba_pkg::SIZE_W + 1;
    localparam ffba_pkg::row_addr_t LAST_ROW = ffba_pkg::ROW_AW'(ffba_pkg::ROWS - 1);
    localparam logic [ffba_pkg::HINT_W-1:0] HEAP_END =
        ffba_pkg::HINT_W'(ffba_pkg::HEAP_WORDS);
    localparam logic [ffba_pkg::OFF_W-1:0] LAST_WORD =
        ffba_pkg::OFF_W'(ffba_pkg::HEAP_WORDS - 1);

    typedef struct packed {
        logic                          found;
        logic [ffba_pkg::SIZE_W-1:0]   len;
        logic [ffba_pkg::HINT_W-1:0]   start;
    } scan_res_t;

    typedef struct packed {
        logic                          found;
        logic [ffba_pkg::HINT_W-1:0]   word;
    } seek_res_t;

    // Extend the free-run tracker across one row of used bits.
    function automatic scan_res_t scan_row(
        input ffba_pkg::row_t               used,
        input ffba_pkg::row_addr_t          row,
        input logic [ffba_pkg::HINT_W-1:0]  hint,
        input logic [ffba_pkg::SIZE_W-1:0]  size,
        input logic [ffba_pkg::SIZE_W-1:0]  len_in,
        input logic [ffba_pkg::HINT_W-1:0]  start_in
    );
        scan_res_t                   r;
        logic [ffba_pkg::HINT_W-1:0] w;
        r.found = 1'b0;
        r.len   = len_in;
        r.start = start_in;
        for (int i = 0; i < ffba_pkg::ROW_BITS; i++)
        begin
            w = ffba_pkg::HINT_W'({row, ffba_pkg::ROW_SH'(i)});
            if (!r.found && w >= hint)
            begin
                if (used[i])
                begin
                    r.len   = '0;
                    r.start = w + ffba_pkg::HINT_W'(1);
                end
                else
                begin
                    r.len = r.len + ffba_pkg::SIZE_W'(1);
                    if (r.len == size)
                    begin
                        r.found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Lowest free word of a row at or above a starting word.
    function automatic seek_res_t seek_row(
        input ffba_pkg::row_t               used,
        input ffba_pkg::row_addr_t          row,
        input logic [ffba_pkg::HINT_W-1:0]  from
    );
        seek_res_t                   r;
        logic [ffba_pkg::HINT_W-1:0] w;
        r.found = 1'b0;
        r.word  = '0;
        for (int i = ffba_pkg::ROW_BITS - 1; i >= 0; i--)
        begin
            w = ffba_pkg::HINT_W'({row, ffba_pkg::ROW_SH'(i)});
            if (!used[i] && w >= from)
            begin
                r.found = 1'b1;
                r.word  = w;
            end
        end
        return r;
    endfunction

    // Bits of a row that fall inside the word range lo..hi.
    function automatic ffba_pkg::row_t range_mask(
        input ffba_pkg::row_addr_t          row,
        input logic [ffba_pkg::OFF_W-1:0]   lo,
        input logic [ffba_pkg::OFF_W-1:0]   hi
    );
        ffba_pkg::row_t             m;
        logic [ffba_pkg::OFF_W-1:0] w;
        m = '0;
        for (int i = 0; i < ffba_pkg::ROW_BITS; i++)
        begin
            w    = {row, ffba_pkg::ROW_SH'(i)};
            m[i] = (w >= lo) && (w <= hi);
        end
        return m;
    endfunction

    ffba_pkg::state_t              state_reg, state_next;
    ffba_pkg::cmd_t                op_reg, op_next;
    logic [ffba_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ffba_pkg::HINT_W-1:0]   hint_reg, hint_next;
    logic [ffba_pkg::HINT_W-1:0]   start_reg, start_next;
    logic [ffba_pkg::SIZE_W-1:0]   len_reg, len_next;
    ffba_pkg::row_addr_t           row_reg, row_next;
    logic [ffba_pkg::OFF_W-1:0]    lo_reg, lo_next;
    logic [ffba_pkg::OFF_W-1:0]    hi_reg, hi_next;
    logic                          seek_reg, seek_next;
    logic                          res_status_reg, res_status_next;
    logic [ffba_pkg::OFF_W-1:0]    res_offset_reg, res_offset_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          status_reg, status_next;
    logic [ffba_pkg::OFF_W-1:0]    granted_reg, granted_next;

    ffba_pkg::map_req_t            map_req;
    ffba_pkg::map_rsp_t            map_rsp;

    logic                          accept;
    logic                          can_load;
    logic                          alloc_fail_now;
    logic [CMP_W-1:0]              alloc_room;
    logic [FREE_W-1:0]             free_end;
    logic [ffba_pkg::OFF_W-1:0]    free_hi;
    logic [ffba_pkg::OFF_W-1:0]    alloc_hi;
    logic [ffba_pkg::HINT_W-1:0]   seek_from;
    logic                          last_rmw;
    ffba_pkg::row_t                mask;
    scan_res_t                     scan;
    seek_res_t                     seek;

    ffba_maps u_maps (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rsp   (map_rsp)
    );

    assign accept   = req_valid && !req_stall;
    assign can_load = !rsp_valid_reg || !rsp_stall;

    // An allocate fails at once when it is empty or cannot fit above the hint.
    assign alloc_room     = CMP_W'(HEAP_END) - CMP_W'(hint_reg);
    assign alloc_fail_now = (block_size == '0) || (hint_reg == HEAP_END)
                            || (CMP_W'(block_size) > alloc_room);

    // Clip a free range at the heap end.
    assign free_end = FREE_W'(start_offset) + FREE_W'(block_size) - FREE_W'(1);
    assign free_hi  = (free_end > FREE_W'(LAST_WORD)) ? LAST_WORD
                                                      : free_end[ffba_pkg::OFF_W-1:0];

    assign scan      = scan_row(map_rsp.in_use, row_reg, hint_reg, size_reg, len_reg,
                                start_reg);
    assign alloc_hi  = ffba_pkg::OFF_W'(scan.start + ffba_pkg::HINT_W'(size_reg)
                                        - ffba_pkg::HINT_W'(1));
    assign seek      = seek_row(map_rsp.in_use, row_reg, start_reg);
    assign mask      = range_mask(row_reg, lo_reg, hi_reg);
    assign last_rmw  = (row_reg == hi_reg[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH]);
    assign seek_from = ffba_pkg::HINT_W'(hi_reg) + ffba_pkg::HINT_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        ffba_pkg::CMD_ALLOC:
                            state_next = alloc_fail_now ? ffba_pkg::ST_DONE
                                                        : ffba_pkg::ST_SCAN;
                        ffba_pkg::CMD_FREE:
                            state_next = (block_size == '0) ? ffba_pkg::ST_DONE
                                                            : ffba_pkg::ST_RMW;
                        ffba_pkg::CMD_COMMIT:
                            state_next = ffba_pkg::ST_RMW;
                        default:
                            state_next = ffba_pkg::ST_DONE;
                    endcase
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (scan.found)
                begin
                    state_next = ffba_pkg::ST_RMW;
                end
                else if (row_reg == LAST_ROW)
                begin
                    state_next = ffba_pkg::ST_DONE;
                end
            end
            ffba_pkg::ST_RMW:
            begin
                if (last_rmw)
                begin
                    if (op_reg == ffba_pkg::CMD_ALLOC && seek_reg && seek_from != HEAP_END)
                    begin
                        state_next = ffba_pkg::ST_SEEK_RD;
                    end
                    else
                    begin
                        state_next = ffba_pkg::ST_DONE;
                    end
                end
            end
            ffba_pkg::ST_SEEK_RD:
            begin
                state_next = ffba_pkg::ST_SEEK;
            end
            ffba_pkg::ST_SEEK:
            begin
                if (seek.found || row_reg == LAST_ROW)
                begin
                    state_next = ffba_pkg::ST_DONE;
                end
            end
            ffba_pkg::ST_DONE:
            begin
                if (can_load)
                begin
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses and handshake. Each read-modify-write pass reads the next row while
    // it writes back the current one; the seek pass goes through ST_SEEK_RD first so that
    // it never reads the row written last.
    always_comb
    begin
        map_req   = '0;
        req_stall = (state_reg != ffba_pkg::ST_IDLE);
        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        ffba_pkg::CMD_ALLOC:
                        begin
                            map_req.rd_en  = !alloc_fail_now;
                            map_req.rd_row = hint_reg[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                        end
                        ffba_pkg::CMD_FREE:
                        begin
                            map_req.rd_en  = (block_size != '0);
                            map_req.rd_row = start_offset[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                        end
                        ffba_pkg::CMD_COMMIT:
                        begin
                            map_req.rd_en  = 1'b1;
                            map_req.rd_row = '0;
                        end
                        default:
                        begin
                            map_req.rd_en = 1'b0;
                        end
                    endcase
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (scan.found)
                begin
                    map_req.rd_en  = 1'b1;
                    map_req.rd_row = scan.start[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                end
                else if (row_reg != LAST_ROW)
                begin
                    map_req.rd_en  = 1'b1;
                    map_req.rd_row = row_reg + ffba_pkg::ROW_AW'(1);
                end
            end
            ffba_pkg::ST_RMW:
            begin
                map_req.wr_row = row_reg;
                case (op_reg)
                    ffba_pkg::CMD_ALLOC:
                    begin
                        map_req.wr_in_use   = 1'b1;
                        map_req.wr_ever     = 1'b1;
                        map_req.in_use_data = map_rsp.in_use | mask;
                        map_req.ever_data   = map_rsp.ever | mask;
                    end
                    ffba_pkg::CMD_FREE:
                    begin
                        map_req.wr_in_use   = 1'b1;
                        map_req.in_use_data = map_rsp.in_use & ~mask;
                    end
                    ffba_pkg::CMD_COMMIT:
                    begin
                        map_req.wr_in_use   = 1'b1;
                        map_req.in_use_data = map_rsp.ever;
                    end
                    default:
                    begin
                        map_req.wr_in_use = 1'b0;
                    end
                endcase
                if (!last_rmw)
                begin
                    map_req.rd_en  = 1'b1;
                    map_req.rd_row = row_reg + ffba_pkg::ROW_AW'(1);
                end
            end
            ffba_pkg::ST_SEEK_RD:
            begin
                map_req.rd_en  = 1'b1;
                map_req.rd_row = row_reg;
            end
            ffba_pkg::ST_SEEK:
            begin
                if (!seek.found && row_reg != LAST_ROW)
                begin
                    map_req.rd_en  = 1'b1;
                    map_req.rd_row = row_reg + ffba_pkg::ROW_AW'(1);
                end
            end
            default:
            begin
                map_req = '0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        op_next         = op_reg;
        size_next       = size_reg;
        hint_next       = hint_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        row_next        = row_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        seek_next       = seek_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    size_next       = block_size;
                    res_status_next = 1'b0;
                    res_offset_next = '0;
                    len_next        = '0;
                    start_next      = hint_reg;
                    seek_next       = 1'b0;
                    case (cmd)
                        ffba_pkg::CMD_ALLOC:
                        begin
                            op_next         = ffba_pkg::CMD_ALLOC;
                            row_next        = hint_reg[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                            res_status_next = alloc_fail_now;
                        end
                        ffba_pkg::CMD_FREE:
                        begin
                            op_next  = ffba_pkg::CMD_FREE;
                            lo_next  = start_offset;
                            hi_next  = free_hi;
                            row_next = start_offset[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                            // Lower the hint even for an empty range.
                            if (ffba_pkg::HINT_W'(start_offset) < hint_reg)
                            begin
                                hint_next = ffba_pkg::HINT_W'(start_offset);
                            end
                        end
                        ffba_pkg::CMD_COMMIT:
                        begin
                            op_next  = ffba_pkg::CMD_COMMIT;
                            lo_next  = '0;
                            hi_next  = LAST_WORD;
                            row_next = '0;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (scan.found)
                begin
                    lo_next         = scan.start[ffba_pkg::OFF_W-1:0];
                    hi_next         = alloc_hi;
                    row_next        = scan.start[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                    seek_next       = (scan.start == hint_reg);
                    res_offset_next = scan.start[ffba_pkg::OFF_W-1:0];
                end
                else if (row_reg == LAST_ROW)
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    row_next   = row_reg + ffba_pkg::ROW_AW'(1);
                    len_next   = scan.len;
                    start_next = scan.start;
                end
            end
            ffba_pkg::ST_RMW:
            begin
                if (last_rmw)
                begin
                    // A run taken at the hint moves the hint to the lowest free word,
                    // which cannot lie below the end of that run.
                    if (op_reg == ffba_pkg::CMD_ALLOC && seek_reg)
                    begin
                        if (seek_from == HEAP_END)
                        begin
                            hint_next = HEAP_END;
                        end
                        else
                        begin
                            start_next = seek_from;
                            row_next   = seek_from[ffba_pkg::OFF_W-1:ffba_pkg::ROW_SH];
                        end
                    end
                end
                else
                begin
                    row_next = row_reg + ffba_pkg::ROW_AW'(1);
                end
            end
            ffba_pkg::ST_SEEK:
            begin
                if (seek.found)
                begin
                    hint_next = seek.word;
                end
                else if (row_reg == LAST_ROW)
                begin
                    hint_next = HEAP_END;
                end
                else
                begin
                    row_next = row_reg + ffba_pkg::ROW_AW'(1);
                end
            end
            ffba_pkg::ST_DONE:
            begin
                if (can_load)
                begin
                    status_next    = res_status_reg;
                    granted_next   = res_offset_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::ST_IDLE;
            hint_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        row_reg        <= row_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        seek_reg       <= seek_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;

endmodule

// File: design/ffba_maps.sv
// In-use and ever-used bitmap memories, one row of words per entry, with per-row valid bits.
module ffba_maps (
    input  logic               clk,
    input  logic               rst_n,
    input  ffba_pkg::map_req_t req,
    output ffba_pkg::map_rsp_t rsp
);

    ffba_pkg::row_t in_use_mem [ffba_pkg::ROWS];
    ffba_pkg::row_t ever_mem   [ffba_pkg::ROWS];

    logic [ffba_pkg::ROWS-1:0] in_use_valid_reg;
    logic [ffba_pkg::ROWS-1:0] ever_valid_reg;

    ffba_pkg::row_t in_use_q_reg;
    ffba_pkg::row_t ever_q_reg;
    logic           in_use_vq_reg;
    logic           ever_vq_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_in_use)
        begin
            in_use_mem[req.wr_row] <= req.in_use_data;
        end
        if (req.wr_ever)
        begin
            ever_mem[req.wr_row] <= req.ever_data;
        end
        if (req.rd_en)
        begin
            in_use_q_reg <= in_use_mem[req.rd_row];
            ever_q_reg   <= ever_mem[req.rd_row];
        end
    end

    // A row never written since reset reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_valid_reg <= '0;
            ever_valid_reg   <= '0;
            in_use_vq_reg    <= 1'b0;
            ever_vq_reg      <= 1'b0;
        end
        else
        begin
            if (req.wr_in_use)
            begin
                in_use_valid_reg[req.wr_row] <= 1'b1;
            end
            if (req.wr_ever)
            begin
                ever_valid_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                in_use_vq_reg <= in_use_valid_reg[req.rd_row];
                ever_vq_reg   <= ever_valid_reg[req.rd_row];
            end
        end
    end

    assign rsp.in_use = in_use_vq_reg ? in_use_q_reg : '0;
    assign rsp.ever   = ever_vq_reg ? ever_q_reg : '0;

endmodule

// File: design/ffba_checker.sv
// Port-level assertions for the first-fit bitmap allocator, bound to the top level.
module ffba_port_props (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic                       status,
    input logic [ffba_pkg::OFF_W-1:0] granted_offset
);

    // One item at a time: an accepted item holds off the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous item still in work");

    // A failed allocation reports offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> granted_offset == '0)
    else $error("failure response with nonzero offset");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(status) && $stable(granted_offset))
    else $error("stalled response changed");

endmodule

bind first_fit_bitmap_allocator ffba_port_props u_ffba_port_props (.*);

// File: bench/ffba_checker.sv
// Checker for the first-fit bitmap allocator: predicts each response and compares it.
module ffba_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [ffba_pkg::CMD_W-1:0]    cmd,
    input  logic [ffba_pkg::SIZE_W-1:0]   block_size,
    input  logic [ffba_pkg::OFF_W-1:0]    start_offset,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic                          status,
    input  logic [ffba_pkg::OFF_W-1:0]    granted_offset,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Room for far more items in flight than the block can ever hold.
    localparam int PEND_DEPTH = 16;
    localparam int PEND_AW    = $clog2(PEND_DEPTH);

    typedef struct packed {
        logic                       status;
        logic [ffba_pkg::OFF_W-1:0] offset;
    } grant_t;

    grant_t                          pending [PEND_DEPTH];
    logic [PEND_AW-1:0]              rd_ptr        = '0;
    logic [PEND_AW-1:0]              wr_ptr        = '0;
    int                              pend_count    = 0;
    grant_t                          want;
    grant_t                          fresh;
    logic [ffba_pkg::HEAP_WORDS-1:0] busy_words    = '0;
    logic [ffba_pkg::HEAP_WORDS-1:0] touched_words = '0;
    logic [ffba_pkg::HINT_W-1:0]     lowest_free   = '0;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void seek_lowest_free();
        lowest_free = ffba_pkg::HINT_W'(ffba_pkg::HEAP_WORDS);
        for (int k = ffba_pkg::HEAP_WORDS - 1; k >= 0; k--)
            if (!busy_words[k])
                lowest_free = ffba_pkg::HINT_W'(k);
    endfunction

    // Scan from the hint; restart just past any busy word that blocks the run.
    function automatic grant_t allocate_run(input int unsigned len);
        grant_t      g;
        int unsigned base;
        int unsigned k;
        bit          blocked;
        g    = '{status: 1'b1, offset: '0};
        base = lowest_free;
        if (len == 0)
            return g;
        while (base < ffba_pkg::HEAP_WORDS && len <= ffba_pkg::HEAP_WORDS - base)
        begin
            blocked = 1'b0;
            for (k = base; k < base + len; k++)
            begin
                if (busy_words[k])
                begin
                    blocked = 1'b1;
                    break;
                end
            end
            if (blocked)
                base = k + 1;
            else
            begin
                for (k = base; k < base + len; k++)
                begin
                    busy_words[k]    = 1'b1;
                    touched_words[k] = 1'b1;
                end
                if (base == lowest_free)
                    seek_lowest_free();
                g.status = 1'b0;
                g.offset = ffba_pkg::OFF_W'(base);
                return g;
            end
        end
        return g;
    endfunction

    function automatic void release_range(input int unsigned from, input int unsigned len);
        for (int unsigned k = from; k < from + len && k < ffba_pkg::HEAP_WORDS; k++)
            busy_words[k] = 1'b0;
        if (from < lowest_free)
            lowest_free = ffba_pkg::HINT_W'(from);
    endfunction

    function automatic grant_t predict_grant(input logic [ffba_pkg::CMD_W-1:0] op,
                                             input logic [ffba_pkg::SIZE_W-1:0] len,
                                             input logic [ffba_pkg::OFF_W-1:0] from);
        grant_t g;
        g = '{status: 1'b0, offset: '0};
        case (op)
            ffba_pkg::CMD_ALLOC:  g = allocate_run(len);
            ffba_pkg::CMD_FREE:   release_range(from, len);
            ffba_pkg::CMD_COMMIT: busy_words = touched_words;
            default:              ;
        endcase
        return g;
    endfunction

    // Pop before push: a response never belongs to the item accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_words    = '0;
            touched_words = '0;
            lowest_free   = '0;
            rd_ptr        = '0;
            wr_ptr        = '0;
            pend_count    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pend_count == 0)
                    report_mismatch("response with no request waiting");
                else
                begin
                    want       = pending[rd_ptr];
                    rd_ptr     = rd_ptr + PEND_AW'(1);
                    pend_count = pend_count - 1;
                    if (status !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  status, want.status));
                    if (granted_offset !== want.offset)
                        report_mismatch($sformatf("granted_offset %0d, expected %0d",
                                                  granted_offset, want.offset));
                end
            end
            if (req_valid && !req_stall)
            begin
                fresh = predict_grant(cmd, block_size, start_offset);
                if (pend_count == PEND_DEPTH)
                    report_mismatch("too many requests without a response");
                else
                begin
                    pending[wr_ptr] = fresh;
                    wr_ptr          = wr_ptr + PEND_AW'(1);
                    pend_count      = pend_count + 1;
                end
            end
            outstanding <= pend_count;
        end
    end

endmodule

// File: bench/first_fit_bitmap_allocator_test.sv
// Testbench top for the first-fit bitmap allocator: stimulus, stalls and verdict.
module first_fit_bitmap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code 3 has no meaning; the block must answer it as a no-op.
    localparam logic [ffba_pkg::CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int                         RANDOM_ITEMS = 1500;
    localparam int                         IDLE_PCT     = 17;
    // Worst allocate: scan, mark and seek passes over all 32 rows, plus slack.
    localparam int                         SETTLE_CYCLES = 150;
    localparam int unsigned                CYCLE_LIMIT   = 1_000_000;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          req_valid    = 1'b0;
    logic                          req_stall;
    logic [ffba_pkg::CMD_W-1:0]    cmd          = '0;
    logic [ffba_pkg::SIZE_W-1:0]   block_size   = '0;
    logic [ffba_pkg::OFF_W-1:0]    start_offset = '0;
    logic                          rsp_valid;
    logic                          rsp_stall    = 1'b0;
    logic                          status;
    logic [ffba_pkg::OFF_W-1:0]    granted_offset;

    int                  mismatches;
    int                  outstanding;
    int unsigned         cycles = 0;
    // While set, neither side idles: back-to-back items and an always-ready receiver.
    bit                  steady = 1'b0;

    always #6 clk = ~clk;

    first_fit_bitmap_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .block_size     (block_size),
        .start_offset   (start_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .granted_offset (granted_offset)
    );

    ffba_checker watcher (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .block_size     (block_size),
        .start_offset   (start_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .granted_offset (granted_offset),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Stall the response side at random, one decision per cycle, so that stalls
    // land on every phase of a scan, a mark pass or a commit.
    always @(posedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Called right after a
    // rising edge; valid stays high into the next item unless an idle gap comes.
    task automatic send_item(input logic [ffba_pkg::CMD_W-1:0] op,
                             input logic [ffba_pkg::SIZE_W-1:0] len,
                             input logic [ffba_pkg::OFF_W-1:0] from);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        cmd          <= op;
        block_size   <= len;
        start_offset <= from;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Drop valid and hold until every predicted response has come back. The first
    // edge lets the count pick up an item accepted at the edge just passed.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly small runs so the heap fragments and refills; a few huge sizes reach
    // past the heap end and exercise the oversized paths.
    task automatic send_random_item();
        int unsigned pick;
        int unsigned sz;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                sz = 0;
            else if (pick < 80)
                sz = $urandom_range(16, 1);
            else if (pick < 95)
                sz = $urandom_range(64, 17);
            else
                sz = $urandom_range(511, 65);
            send_item(ffba_pkg::CMD_ALLOC, ffba_pkg::SIZE_W'(sz),
                      ffba_pkg::OFF_W'($urandom));
        end
        else if (pick < 88)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                sz = 0;
            else if (pick < 85)
                sz = $urandom_range(40, 1);
            else
                sz = $urandom_range(511, 41);
            send_item(ffba_pkg::CMD_FREE, ffba_pkg::SIZE_W'(sz),
                      ffba_pkg::OFF_W'($urandom));
        end
        else if (pick < 96)
            send_item(ffba_pkg::CMD_COMMIT, ffba_pkg::SIZE_W'($urandom),
                      ffba_pkg::OFF_W'($urandom));
        else
            send_item(CMD_UNUSED, ffba_pkg::SIZE_W'($urandom),
                      ffba_pkg::OFF_W'($urandom));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: rejected sizes, a full heap, edge frees, commit, no-op.
        send_item(ffba_pkg::CMD_ALLOC,  9'd0,   8'd0);   // zero-size allocate fails
        send_item(ffba_pkg::CMD_ALLOC,  9'd257, 8'd0);   // one word past the heap
        send_item(ffba_pkg::CMD_ALLOC,  9'd511, 8'd255); // largest size field
        send_item(ffba_pkg::CMD_ALLOC,  9'd256, 8'd0);   // whole heap; hint goes to the end
        send_item(ffba_pkg::CMD_ALLOC,  9'd1,   8'd0);   // full heap refuses
        send_item(ffba_pkg::CMD_FREE,   9'd1,   8'd255); // free the last word
        send_item(ffba_pkg::CMD_ALLOC,  9'd1,   8'd0);   // gets the last word, heap full
        send_item(ffba_pkg::CMD_FREE,   9'd0,   8'd0);   // zero-size free lowers the hint
        send_item(ffba_pkg::CMD_ALLOC,  9'd1,   8'd0);   // scan walks the heap and misses
        send_item(ffba_pkg::CMD_FREE,   9'd511, 8'd16);  // range runs off the heap end
        send_item(ffba_pkg::CMD_FREE,   9'd4,   8'd4);
        send_item(ffba_pkg::CMD_ALLOC,  9'd8,   8'd0);   // skips the 4-word hole
        send_item(ffba_pkg::CMD_ALLOC,  9'd4,   8'd0);   // fills the hole, no seek
        send_item(CMD_UNUSED,           9'd511, 8'd255); // unused code, all bits high
        send_item(ffba_pkg::CMD_COMMIT, 9'd0,   8'd0);   // ever-used covers the heap
        send_item(ffba_pkg::CMD_ALLOC,  9'd1,   8'd0);
        send_item(ffba_pkg::CMD_FREE,   9'd256, 8'd0);
        send_item(ffba_pkg::CMD_ALLOC,  9'd255, 8'd0);
        send_item(ffba_pkg::CMD_ALLOC,  9'd2,   8'd0);   // only one word left at the end
        send_item(ffba_pkg::CMD_ALLOC,  9'd1,   8'd0);
        send_item(ffba_pkg::CMD_FREE,   9'd300, 8'd128);
        send_item(ffba_pkg::CMD_ALLOC,  9'd128, 8'd0);
        send_item(ffba_pkg::CMD_FREE,   9'd256, 8'd0);   // clean slate for the random part
        drain_responses();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Let the pipeline run dry a couple of times mid-stream.
            if (n == 500 || n == 1000)
                drain_responses();
            steady = (n >= 700 && n < 900);
            send_random_item();
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
